@@ sv/range_grid_object_classifier_macros.svh @@
// assertion macros for the range grid object classifier
// included by the top level; no other dependencies
`ifndef RANGE_GRID_OBJECT_CLASSIFIER_MACROS_SVH
`define RANGE_GRID_OBJECT_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define RGOC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rgoc assertion failed");
`define RGOC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rgoc assertion failed");
`else
`define RGOC_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define RGOC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

@@ sv/rgoc_pkg.sv @@
// shared types, codes and defaults for the range grid object classifier
// no dependencies
package rgoc_pkg;

  localparam int GRID_ROWS_DEF = 8;
  localparam int GRID_COLS_DEF = 8;
  localparam int DIST_FIELDS   = 8;
  localparam int DIST_W        = 16;
  localparam int CNT_W         = 16;

  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_SINGLE = 2'd1;
  localparam logic [1:0] CLS_DOUBLE = 2'd2;
  localparam logic [1:0] CLS_NONE   = 2'd3;

  localparam logic [1:0] EVT_NONE   = 2'd0;
  localparam logic [1:0] EVT_CHANGE = 2'd1;
  localparam logic [1:0] EVT_VOID   = 2'd2;

  localparam logic [1:0] REG_NEAR_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GAP_MIN        = 2'd1;
  localparam logic [1:0] REG_DOUBLE_VOTES   = 2'd2;
  localparam logic [1:0] REG_STABLE_FRAMES  = 2'd3;

  localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd127;
  localparam logic [2:0]  GAP_MIN_RST        = 3'd3;
  localparam logic [2:0]  DOUBLE_VOTES_RST   = 3'd3;
  localparam logic [3:0]  STABLE_FRAMES_RST  = 4'd3;

  localparam logic [3:0]       RUN_MAX   = 4'd15;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef logic [DIST_FIELDS-1:0][DIST_W-1:0] dist_arr_t;

  typedef struct packed {
    logic [DIST_W-1:0] near_threshold;
    logic [2:0]        gap_min;
  } row_cfg_t;

endpackage

@@ sv/rgoc_if.sv @@
// valid/ready channel interfaces for row words and result words
// depends on nothing
interface rgoc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  row_index;
  logic [15:0] dist_0;
  logic [15:0] dist_1;
  logic [15:0] dist_2;
  logic [15:0] dist_3;
  logic [15:0] dist_4;
  logic [15:0] dist_5;
  logic [15:0] dist_6;
  logic [15:0] dist_7;

  modport source (output valid, row_index, dist_0, dist_1, dist_2, dist_3, dist_4,
                  dist_5, dist_6, dist_7, input ready);
  modport sink (input valid, row_index, dist_0, dist_1, dist_2, dist_3, dist_4,
                dist_5, dist_6, dist_7, output ready);
endinterface

interface rgoc_out_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic [1:0]  frame_class;
  logic [1:0]  shown_state;
  logic [1:0]  change_event;
  logic [15:0] empty_total;
  logic [15:0] single_total;
  logic [15:0] double_total;
  logic [15:0] change_total;

  modport source (output valid, frame_done, frame_class, shown_state, change_event,
                  empty_total, single_total, double_total, change_total, input ready);
  modport sink (input valid, frame_done, frame_class, shown_state, change_event,
                empty_total, single_total, double_total, change_total, output ready);
endinterface

@@ sv/rgoc_row_class.sv @@
// classifies one grid row as empty, single or double from its distances
// depends on rgoc_pkg
module rgoc_row_class
  import rgoc_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  dist_arr_t  dist_in,
  input  row_cfg_t   cfg,
  output logic [1:0] row_cls
);

  localparam int NC = (GRID_COLS < DIST_FIELDS) ? GRID_COLS : DIST_FIELDS;

  always_comb begin
    logic       started;
    logic       gap_seen;
    logic       anything;
    logic       dbl;
    logic       hit;
    logic [2:0] misses;
    started  = 1'b0;
    gap_seen = 1'b0;
    anything = 1'b0;
    dbl      = 1'b0;
    misses   = 3'd0;
    for (int c = 0; c < NC; c++) begin
      hit = dist_in[c] <= cfg.near_threshold;
      if (hit) begin
        anything = 1'b1;
        if (started && gap_seen) begin
          dbl = 1'b1;
        end
        started = 1'b1;
        misses  = 3'd0;
      end else if (started) begin
        if (misses != 3'd7) begin
          misses = misses + 3'd1;
        end
        if (misses >= cfg.gap_min) begin
          gap_seen = 1'b1;
        end
      end
    end
    if (dbl) begin
      row_cls = CLS_DOUBLE;
    end else if (anything) begin
      row_cls = CLS_SINGLE;
    end else begin
      row_cls = CLS_EMPTY;
    end
  end

endmodule

@@ sv/range_grid_object_classifier.sv @@
// top level: row register, row classifier, frame vote, debounce and counters
// depends on rgoc_pkg, rgoc_if, rgoc_row_class and the macros header
`include "range_grid_object_classifier_macros.svh"

// Takes one grid row per clock while in ready is high and returns one result
// word per row via the row register and then the result register. Row classes
// are kept in a small register file; the last row of a frame triggers the vote
// over the other rows, the stability debounce and the counter update in the
// same cycle, so frames need no extra time. in ready drops only when both the
// row register and the result register hold words the sink has not taken.
module range_grid_object_classifier
  import rgoc_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rgoc_in_if.sink     in_ch,
  rgoc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam logic [4:0] ROWS_N = 5'(GRID_ROWS);
  localparam logic [4:0] LAST_ROW = 5'(GRID_ROWS - 1);

  // configuration
  logic [15:0] near_thr_r;
  logic [2:0]  gap_min_r;
  logic [2:0]  dbl_votes_r;
  logic [3:0]  stable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_thr_r  <= NEAR_THRESHOLD_RST;
      gap_min_r   <= GAP_MIN_RST;
      dbl_votes_r <= DOUBLE_VOTES_RST;
      stable_r    <= STABLE_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEAR_THRESHOLD: near_thr_r  <= cfg_data;
        REG_GAP_MIN:        gap_min_r   <= cfg_data[2:0];
        REG_DOUBLE_VOTES:   dbl_votes_r <= cfg_data[2:0];
        REG_STABLE_FRAMES:  stable_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_v_r, s1_v_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv, in_fire, s1_fire;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_fire      = s1_v_r && adv;
  assign out_ch.valid = out_valid_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // row register
  logic [2:0] row_r;
  dist_arr_t  dist_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r  <= in_ch.row_index;
      dist_r <= {in_ch.dist_7, in_ch.dist_6, in_ch.dist_5, in_ch.dist_4,
                 in_ch.dist_3, in_ch.dist_2, in_ch.dist_1, in_ch.dist_0};
    end
  end

  // row classification
  row_cfg_t   row_cfg;
  logic [1:0] row_cls;

  assign row_cfg.near_threshold = near_thr_r;
  assign row_cfg.gap_min        = gap_min_r;

  rgoc_row_class #(
    .GRID_COLS (GRID_COLS)
  ) u_row_class (
    .dist_in (dist_r),
    .cfg     (row_cfg),
    .row_cls (row_cls)
  );

  logic [4:0]    row_ext;
  logic          row_ok;
  logic          row_last;
  logic [RW-1:0] row_idx;

  assign row_ext  = {2'b00, row_r};
  assign row_ok   = row_ext < ROWS_N;
  assign row_last = row_ext == LAST_ROW;
  assign row_idx  = row_ext[RW-1:0];

  // row class store
  logic [1:0] store_r [GRID_ROWS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        store_r[r] <= CLS_SINGLE;
      end
    end else if (s1_fire && row_ok) begin
      store_r[row_idx] <= row_cls;
    end
  end

  // frame vote over all rows but the last
  logic [RW-1:0] doubles;
  logic          nonempty;
  logic [1:0]    frame_cls;

  always_comb begin
    doubles  = '0;
    nonempty = 1'b0;
    for (int r = 0; r < GRID_ROWS - 1; r++) begin
      if (store_r[r] == CLS_DOUBLE) begin
        doubles = doubles + RW'(1);
      end
      if (store_r[r] != CLS_EMPTY) begin
        nonempty = 1'b1;
      end
    end
    if (5'(doubles) >= 5'(dbl_votes_r)) begin
      frame_cls = CLS_DOUBLE;
    end else if (nonempty) begin
      frame_cls = CLS_SINGLE;
    end else begin
      frame_cls = CLS_EMPTY;
    end
  end

  // debounce and counters
  logic [1:0]       cand_r, cand_nxt;
  logic [3:0]       run_r, run_nxt;
  logic [1:0]       conf_r, conf_nxt;
  logic [1:0]       prev_r, prev_nxt;
  logic [CNT_W-1:0] empty_r, empty_nxt;
  logic [CNT_W-1:0] single_r, single_nxt;
  logic [CNT_W-1:0] double_r, double_nxt;
  logic [CNT_W-1:0] change_r, change_nxt;
  logic [1:0]       event_nxt;
  logic             frame_go;

  assign frame_go = row_ok && row_last;

  always_comb begin
    cand_nxt   = cand_r;
    run_nxt    = run_r;
    conf_nxt   = conf_r;
    prev_nxt   = prev_r;
    empty_nxt  = empty_r;
    single_nxt = single_r;
    double_nxt = double_r;
    change_nxt = change_r;
    event_nxt  = EVT_NONE;
    if (frame_go) begin
      if (frame_cls == cand_r) begin
        if (run_r != RUN_MAX) begin
          run_nxt = run_r + 4'd1;
        end
      end else begin
        cand_nxt = frame_cls;
        run_nxt  = 4'd1;
      end
      if (run_nxt >= stable_r && cand_nxt != conf_r) begin
        if (cand_nxt == CLS_EMPTY && conf_r == CLS_SINGLE && prev_r == CLS_EMPTY) begin
          if (change_r != '0) begin
            change_nxt = change_r - CNT_W'(1);
          end
          if (single_r != '0) begin
            single_nxt = single_r - CNT_W'(1);
          end
          conf_nxt  = CLS_EMPTY;
          event_nxt = EVT_VOID;
        end else begin
          prev_nxt = conf_r;
          conf_nxt = cand_nxt;
          case (cand_nxt)
            CLS_EMPTY: begin
              if (empty_r != COUNT_MAX) empty_nxt = empty_r + CNT_W'(1);
            end
            CLS_SINGLE: begin
              if (single_r != COUNT_MAX) single_nxt = single_r + CNT_W'(1);
            end
            default: begin
              if (double_r != COUNT_MAX) double_nxt = double_r + CNT_W'(1);
            end
          endcase
          if (change_r != COUNT_MAX) begin
            change_nxt = change_r + CNT_W'(1);
          end
          event_nxt = EVT_CHANGE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r   <= CLS_NONE;
      run_r    <= 4'd0;
      conf_r   <= CLS_NONE;
      prev_r   <= CLS_NONE;
      empty_r  <= '0;
      single_r <= '0;
      double_r <= '0;
      change_r <= '0;
    end else if (s1_fire) begin
      cand_r   <= cand_nxt;
      run_r    <= run_nxt;
      conf_r   <= conf_nxt;
      prev_r   <= prev_nxt;
      empty_r  <= empty_nxt;
      single_r <= single_nxt;
      double_r <= double_nxt;
      change_r <= change_nxt;
    end
  end

  // result register
  logic       out_done_r;
  logic [1:0] out_class_r;
  logic [1:0] out_shown_r;
  logic [1:0] out_event_r;
  logic [15:0] out_empty_r, out_single_r, out_double_r, out_change_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_done_r   <= frame_go;
      out_class_r  <= frame_go ? frame_cls : CLS_EMPTY;
      out_shown_r  <= conf_nxt;
      out_event_r  <= event_nxt;
      out_empty_r  <= empty_nxt;
      out_single_r <= single_nxt;
      out_double_r <= double_nxt;
      out_change_r <= change_nxt;
    end
  end

  assign out_ch.frame_done   = out_done_r;
  assign out_ch.frame_class  = out_class_r;
  assign out_ch.shown_state  = out_shown_r;
  assign out_ch.change_event = out_event_r;
  assign out_ch.empty_total  = out_empty_r;
  assign out_ch.single_total = out_single_r;
  assign out_ch.double_total = out_double_r;
  assign out_ch.change_total = out_change_r;

  // checks
  logic void_word;
  logic row_word;
  logic quiet_word;

  assign void_word  = out_valid_r && out_event_r == EVT_VOID;
  assign row_word   = out_valid_r && !out_done_r;
  assign quiet_word = out_event_r == EVT_NONE && out_class_r == CLS_EMPTY;

  `RGOC_ASSERT_NEXT(a_frame_word, clk, rst_n, s1_fire && frame_go, out_valid_r && out_done_r)
  `RGOC_ASSERT_SAME(a_void_shows_empty, clk, rst_n, void_word, out_shown_r == CLS_EMPTY)
  `RGOC_ASSERT_SAME(a_row_word_quiet, clk, rst_n, row_word, quiet_word)
  `RGOC_ASSERT_NEXT(a_conf_sticks, clk, rst_n, conf_r != CLS_NONE, conf_r != CLS_NONE)

endmodule
